FILE: src/bdsb_pkg.sv
// Shared constants, types and constant tables for the brush dab blend unit.
// Tables are built at elaboration time from the functions below.
// No dependencies.
package bdsb_pkg;

	localparam int MAX_SIDE  = 4096;
	localparam int SIDE_W    = 13;
	localparam int FT_DEPTH  = 256;
	localparam int TAB_AW    = $clog2(FT_DEPTH + 1);
	localparam int TAB_W     = 18;
	localparam int POS_W     = 16 + TAB_AW;

	localparam int Q16_ONE   = 65536;
	localparam int EXP_BASE  = 22938;
	localparam int EXP_SLOPE = 108134;
	localparam int ALPHA_EPS = 167;
	localparam int SRC_ONE   = 65536 * 255;
	localparam int RF_MIN    = 16;
	localparam int RF_MAX    = 32768;

	localparam logic [63:0] K_ONE      = 64'd65536 * 64'd255 * 64'd255;
	localparam logic [63:0] VANISH_LIM = (K_ONE + 64'd999) / 64'd1000;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_STAMP_U       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STAMP_V       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_FRAC   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HARDNESS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_COLOR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE_MODE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 3'd7;

	// result selection codes
	localparam logic [1:0] SEL_DST   = 2'd0;
	localparam logic [1:0] SEL_ERASE = 2'd1;
	localparam logic [1:0] SEL_ZERO  = 2'd2;
	localparam logic [1:0] SEL_BLEND = 2'd3;

	typedef logic [FT_DEPTH:0][TAB_W-1:0] tab_t;

	typedef struct packed {
		logic       inb;
		logic       touched;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pix_car_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem  = v;
		res  = '0;
		bitv = 64'd1 << 62;
		while (bitv > rem) bitv = bitv >> 2;
		while (bitv != 64'd0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// log2(1+i/D) in Q16, by repeated squaring
	function automatic tab_t build_lg();
		tab_t tab;
		logic [63:0] x;
		logic [63:0] res;
		tab = '0;
		for (int i = 0; i < FT_DEPTH; i++) begin
			x   = ((64'(FT_DEPTH) + 64'(i)) << 30) / 64'(FT_DEPTH);
			res = '0;
			for (int b = 15; b >= 0; b--) begin
				x = (x * x) >> 30;
				if (x >= (64'd2 << 30)) begin
					x      = x >> 1;
					res[b] = 1'b1;
				end
			end
			tab[i] = TAB_W'(res);
		end
		tab[FT_DEPTH] = TAB_W'(Q16_ONE);
		return tab;
	endfunction

	// 2^(j/D) in Q16, from Q30 square roots of two
	function automatic tab_t build_ex();
		tab_t tab;
		logic [63:0] f;
		logic [63:0] acc;
		logic [63:0] r;
		tab = '0;
		for (int j = 0; j <= FT_DEPTH; j++) begin
			f = (64'(j) << 16) / 64'(FT_DEPTH);
			if (f >= 64'(Q16_ONE)) begin
				tab[j] = TAB_W'(2 * Q16_ONE);
			end else begin
				acc = 64'd1 << 30;
				r   = 64'd2 << 30;
				for (int k = 15; k >= 0; k--) begin
					r = isqrt64(r << 30);
					if (f[k]) acc = (acc * r) >> 30;
				end
				tab[j] = TAB_W'(acc >> 14);
			end
		end
		return tab;
	endfunction

	localparam tab_t LG_TAB = build_lg();
	localparam tab_t EX_TAB = build_ex();

	// floor(v/255) by reciprocal and one correction step
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [24:0] m;
		logic [8:0]  q;
		logic [16:0] r;
		m = 25'(v) * 25'd257;
		q = m[24:16];
		r = 17'(v) - 17'(q) * 17'd255;
		if (r >= 17'd255) q = q + 9'd1;
		return q[7:0];
	endfunction

endpackage

FILE: src/bdsb_intf.sv
// Channel interfaces of the brush dab blend unit: pixel request in,
// pixel result out and configuration writes. Depends on bdsb_pkg.
interface bdsb_pix_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [7:0]  dst_red;
	logic [7:0]  dst_green;
	logic [7:0]  dst_blue;
	logic [7:0]  dst_alpha;
	modport source(output valid, pixel_x, pixel_y, dst_red, dst_green, dst_blue, dst_alpha,
		input ready);
	modport sink(input valid, pixel_x, pixel_y, dst_red, dst_green, dst_blue, dst_alpha,
		output ready);
endinterface

interface bdsb_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic       pixel_touched;
	modport source(output valid, out_red, out_green, out_blue, out_alpha, pixel_touched,
		input ready);
	modport sink(input valid, out_red, out_green, out_blue, out_alpha, pixel_touched,
		output ready);
endinterface

interface bdsb_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bdsb_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: src/brush_disc_stamp_blend_unit.sv
// Soft round brush dab applied to a stream of canvas pixels.
// Depends on bdsb_pkg and the interfaces in bdsb_intf.sv.
//
// Usage:
// - cfg takes register writes (index, data) and is always ready. Write the
//   registers only while no pixel request is in flight.
// - pix_in takes one request (position, current RGBA) per cycle if not stalled.
// - pix_out gives one result per request, in order: the new RGBA and a flag
//   that tells whether the pixel lay inside the dab.
// - Throughput is one pixel per cycle while pix_out does not stall. The depth
//   is set by the square root (one result bit per stage), the divide by the
//   radius (one quotient bit per stage) and the colour divides (eight stages).
// - When pix_out stalls, the whole pipeline holds and pix_in.ready drops in
//   the same cycle; nothing is lost or repeated. Bubbles stay in place.
// - Reset (arst_n low) empties the pipeline and loads the register defaults:
//   centre dab, radius fraction 1638, hardness one half, opaque white,
//   paint mode, 1024 by 1024 canvas.
module brush_disc_stamp_blend_unit (
	input logic clk,
	input logic arst_n,
	bdsb_cfg_if.sink cfg,
	bdsb_pix_in_if.sink pix_in,
	bdsb_pix_out_if.source pix_out
);

	localparam int NST  = 75;
	localparam int SQ_N = 29;
	localparam int DV_N = 17;
	localparam int CD_N = 8;
	localparam int POS_W_L  = bdsb_pkg::POS_W;
	localparam int TAB_AW_L = bdsb_pkg::TAB_AW;

	// configuration registers
	logic [15:0] stamp_u_q, stamp_v_q, radius_fraction_q, hardness_q;
	logic [31:0] brush_color_q;
	logic        erase_mode_q;
	logic [12:0] canvas_width_q, canvas_height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_u_q         <= 16'd32768;
			stamp_v_q         <= 16'd32768;
			radius_fraction_q <= 16'd1638;
			hardness_q        <= 16'd32768;
			brush_color_q     <= 32'hFFFF_FFFF;
			erase_mode_q      <= 1'b0;
			canvas_width_q    <= 13'd1024;
			canvas_height_q   <= 13'd1024;
		end else if (cfg.valid) begin
			case (cfg.index)
				bdsb_pkg::CFG_STAMP_U:       stamp_u_q <= cfg.data[15:0];
				bdsb_pkg::CFG_STAMP_V:       stamp_v_q <= cfg.data[15:0];
				bdsb_pkg::CFG_RADIUS_FRAC:   radius_fraction_q <= cfg.data[15:0];
				bdsb_pkg::CFG_HARDNESS:      hardness_q <= cfg.data[15:0];
				bdsb_pkg::CFG_BRUSH_COLOR:   brush_color_q <= cfg.data;
				bdsb_pkg::CFG_ERASE_MODE:    erase_mode_q <= cfg.data[0];
				bdsb_pkg::CFG_CANVAS_WIDTH:  canvas_width_q <= cfg.data[12:0];
				bdsb_pkg::CFG_CANVAS_HEIGHT: canvas_height_q <= cfg.data[12:0];
				default: ;
			endcase
		end
	end

	// values derived from the registers
	logic [12:0] w_sat, h_sat, min_side;
	logic [15:0] rf_sat;
	logic [27:0] rad_prod;
	logic [13:0] rad_n;
	logic [33:0] e_prod;
	logic [13:0] rad_q;
	logic [27:0] rad2_q;
	logic [27:0] cxq_q, cyq_q;
	logic [17:0] e_q;
	logic [12:0] w_m1, h_m1;

	always_comb begin
		w_sat = (canvas_width_q > 13'(bdsb_pkg::MAX_SIDE)) ?
			13'(bdsb_pkg::MAX_SIDE) : canvas_width_q;
		h_sat = (canvas_height_q > 13'(bdsb_pkg::MAX_SIDE)) ?
			13'(bdsb_pkg::MAX_SIDE) : canvas_height_q;
		min_side = (w_sat < h_sat) ? w_sat : h_sat;
		rf_sat = radius_fraction_q;
		if (rf_sat < 16'(bdsb_pkg::RF_MIN)) rf_sat = 16'(bdsb_pkg::RF_MIN);
		if (rf_sat > 16'(bdsb_pkg::RF_MAX)) rf_sat = 16'(bdsb_pkg::RF_MAX);
		rad_prod = 28'(rf_sat) * 28'(min_side) + 28'd8192;
		rad_n = (rad_prod[27:14] == 14'd0) ? 14'd1 : rad_prod[27:14];
		e_prod = 34'(hardness_q) * 34'(bdsb_pkg::EXP_SLOPE) + 34'd32768;
		w_m1 = w_sat - 13'd1;
		h_m1 = h_sat - 13'd1;
	end

	always_ff @(posedge clk) begin
		rad_q  <= rad_n;
		rad2_q <= 28'(rad_q) * 28'(rad_q);
		cxq_q  <= 28'(stamp_u_q) * 28'(w_m1[11:0]);
		cyq_q  <= 28'(stamp_v_q) * 28'(h_m1[11:0]);
		e_q    <= 18'(e_prod[33:16]) + 18'(bdsb_pkg::EXP_BASE);
	end

	// pipeline control: every stage advances together
	logic [NST:1] vld_s;
	logic adv, acc;

	assign adv          = !vld_s[NST] || pix_out.ready;
	assign pix_in.ready = adv;
	assign acc          = pix_in.valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-1:1], acc};
		end
	end

	// per-pixel carry: destination colour and flags
	bdsb_pkg::pix_car_t car_s [1:NST-1];
	bdsb_pkg::pix_car_t car2_n, car6_n;
	logic inb_n, inside_n;

	// geometry stages
	logic [11:0] x_s1, y_s1, x_s2, y_s2;
	logic [27:0] adx_s3, ady_s3;
	logic [55:0] sqx_s4, sqy_s4;
	logic [56:0] d2_s5;
	logic [27:0] xq, yq;

	assign inb_n = (w_sat != 13'd0) && (h_sat != 13'd0) &&
		({1'b0, x_s1} < w_sat) && ({1'b0, y_s1} < h_sat);
	assign inside_n = 60'(d2_s5) <= {rad2_q, 32'd0};
	assign xq = {x_s2, 16'd0};
	assign yq = {y_s2, 16'd0};

	// merge the canvas and disc flags into the carry
	always_comb begin
		car2_n         = car_s[1];
		car2_n.inb     = inb_n;
		car6_n         = car_s[5];
		car6_n.touched = car_s[5].inb && inside_n;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= pix_in.pixel_x;
			y_s1 <= pix_in.pixel_y;
			car_s[1] <= '{inb: 1'b0, touched: 1'b0, r: pix_in.dst_red, g: pix_in.dst_green,
				b: pix_in.dst_blue, a: pix_in.dst_alpha};
			car_s[2] <= car2_n;
			for (int i = 3; i < NST; i++) car_s[i] <= (i == 6) ? car6_n : car_s[i-1];
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			adx_s3 <= (xq >= cxq_q) ? xq - cxq_q : cxq_q - xq;
			ady_s3 <= (yq >= cyq_q) ? yq - cyq_q : cyq_q - yq;
			sqx_s4 <= 56'(adx_s3) * 56'(adx_s3);
			sqy_s4 <= 56'(ady_s3) * 56'(ady_s3);
			d2_s5  <= 57'(sqx_s4) + 57'(sqy_s4);
		end
	end

	// integer square root, one result bit per stage (index 0 is stage 6)
	logic [57:0]     sq_val_s  [0:SQ_N];
	logic [30:0]     sq_rem_s  [0:SQ_N];
	logic [SQ_N-1:0] sq_root_s [0:SQ_N];
	logic [57:0]     sq_val_n  [1:SQ_N];
	logic [30:0]     sq_rem_n  [1:SQ_N];
	logic [SQ_N-1:0] sq_root_n [1:SQ_N];

	always_comb begin
		logic [32:0] rem2;
		logic [32:0] trial;
		for (int i = 1; i <= SQ_N; i++) begin
			rem2  = {sq_rem_s[i-1][30:0], sq_val_s[i-1][57:56]};
			trial = {2'b00, sq_root_s[i-1], 2'b01};
			sq_val_n[i] = {sq_val_s[i-1][55:0], 2'b00};
			if (rem2 >= trial) begin
				sq_rem_n[i]  = 31'(rem2 - trial);
				sq_root_n[i] = {sq_root_s[i-1][SQ_N-2:0], 1'b1};
			end else begin
				sq_rem_n[i]  = 31'(rem2);
				sq_root_n[i] = {sq_root_s[i-1][SQ_N-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_val_s[0]  <= {1'b0, d2_s5};
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			for (int i = 1; i <= SQ_N; i++) begin
				sq_val_s[i]  <= sq_val_n[i];
				sq_rem_s[i]  <= sq_rem_n[i];
				sq_root_s[i] <= sq_root_n[i];
			end
		end
	end

	// distance over radius, one quotient bit per stage (index 0 is stage 36)
	logic [30:0]     dv_rem_s [0:DV_N];
	logic [DV_N-1:0] dv_q_s   [0:DV_N];
	logic [30:0]     dv_rem_n [1:DV_N];
	logic [DV_N-1:0] dv_q_n   [1:DV_N];

	always_comb begin
		logic [30:0] sub;
		for (int j = 1; j <= DV_N; j++) begin
			sub = 31'(rad_q) << (DV_N - j);
			dv_rem_n[j] = dv_rem_s[j-1];
			dv_q_n[j]   = dv_q_s[j-1];
			if (dv_rem_s[j-1] >= sub) begin
				dv_rem_n[j]         = dv_rem_s[j-1] - sub;
				dv_q_n[j][DV_N - j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_rem_s[0] <= 31'(sq_root_s[SQ_N]);
			dv_q_s[0]   <= '0;
			for (int j = 1; j <= DV_N; j++) begin
				dv_rem_s[j] <= dv_rem_n[j];
				dv_q_s[j]   <= dv_q_n[j];
			end
		end
	end

	// falloff t^e = exp2(e * log2 t), stages 54 to 62
	logic        tz_s54, tone_s54, tz_s55, tone_s55, tz_s56, tone_s56, tz_s57, tone_s57;
	logic        tz_s58, tone_s58, tz_s59, tone_s59, tz_s60, tone_s60, tz_s61, tone_s61;
	logic [15:0] t_s54, f_s55;
	logic [3:0]  k_s55, k_s56, k_s57;
	logic [17:0] lg_lo_s56, lg_hi_s56, lg_lo_s57;
	logic [15:0] lg_fr_s56;
	logic [33:0] lg_prod_s57;
	logic [20:0] nl_s58;
	logic [21:0] p_s59;
	logic [5:0]  n_s60, n_s61;
	logic        hone_s60, hone_s61;
	logic [17:0] ex_lo_s60, ex_hi_s60, ex_lo_s61;
	logic [15:0] ex_fr_s60;
	logic [33:0] ex_prod_s61;
	logic [16:0] fo_s62;

	logic [3:0]        k_n;
	logic [15:0]       norm_n;
	logic [POS_W_L-1:0] lg_pos_n, ex_pos_n;
	logic [TAB_AW_L-1:0] lg_i_n, ex_i_n;
	logic [17:0]       lgv_n, ev_n;
	logic [15:0]       hf_n;
	logic [16:0]       fo_n;
	logic [38:0]       pe_n;

	always_comb begin
		k_n = 4'd0;
		for (int b = 0; b < 16; b++) begin
			if (t_s54[b]) k_n = 4'(b);
		end
		norm_n   = t_s54 << (4'd15 - k_n);
		lg_pos_n = POS_W_L'(f_s55) * POS_W_L'(bdsb_pkg::FT_DEPTH);
		lg_i_n   = lg_pos_n[POS_W_L-1:16];
		lgv_n    = lg_lo_s57 + lg_prod_s57[33:16];
		pe_n     = 39'(nl_s58) * 39'(e_q);
		hf_n     = 16'(17'(bdsb_pkg::Q16_ONE) - 17'(p_s59[15:0]));
		ex_pos_n = POS_W_L'(hf_n) * POS_W_L'(bdsb_pkg::FT_DEPTH);
		ex_i_n   = ex_pos_n[POS_W_L-1:16];
		ev_n     = hone_s61 ? 18'(2 * bdsb_pkg::Q16_ONE) : ex_lo_s61 + ex_prod_s61[33:16];
		if (tz_s61) begin
			fo_n = '0;
		end else if (tone_s61) begin
			fo_n = 17'(bdsb_pkg::Q16_ONE);
		end else if (n_s61 >= 6'd31) begin
			fo_n = '0;
		end else begin
			fo_n = 17'(ev_n >> (n_s61 + 6'd1));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tz_s54   <= dv_q_s[DV_N][16];
			tone_s54 <= dv_q_s[DV_N] == '0;
			t_s54    <= 16'(17'(bdsb_pkg::Q16_ONE) - dv_q_s[DV_N]);
			tz_s55 <= tz_s54;  tone_s55 <= tone_s54;
			k_s55  <= k_n;
			f_s55  <= {norm_n[14:0], 1'b0};
			tz_s56 <= tz_s55;  tone_s56 <= tone_s55;
			k_s56  <= k_s55;
			lg_lo_s56 <= bdsb_pkg::LG_TAB[lg_i_n];
			lg_hi_s56 <= bdsb_pkg::LG_TAB[lg_i_n + TAB_AW_L'(1)];
			lg_fr_s56 <= lg_pos_n[15:0];
			tz_s57 <= tz_s56;  tone_s57 <= tone_s56;
			k_s57  <= k_s56;
			lg_lo_s57   <= lg_lo_s56;
			lg_prod_s57 <= 34'(lg_hi_s56 - lg_lo_s56) * 34'(lg_fr_s56);
			tz_s58 <= tz_s57;  tone_s58 <= tone_s57;
			nl_s58 <= {5'(5'd16 - 5'(k_s57)), 16'd0} - 21'(lgv_n);
			tz_s59 <= tz_s58;  tone_s59 <= tone_s58;
			p_s59  <= pe_n[37:16];
			tz_s60 <= tz_s59;  tone_s60 <= tone_s59;
			n_s60     <= p_s59[21:16];
			hone_s60  <= p_s59[15:0] == 16'd0;
			ex_lo_s60 <= bdsb_pkg::EX_TAB[ex_i_n];
			ex_hi_s60 <= bdsb_pkg::EX_TAB[ex_i_n + TAB_AW_L'(1)];
			ex_fr_s60 <= ex_pos_n[15:0];
			tz_s61 <= tz_s60;  tone_s61 <= tone_s60;
			n_s61       <= n_s60;
			hone_s61    <= hone_s60;
			ex_lo_s61   <= ex_lo_s60;
			ex_prod_s61 <= 34'(ex_hi_s60 - ex_lo_s60) * 34'(ex_fr_s60);
			fo_s62 <= fo_n;
		end
	end

	// blend, stages 63 to 66
	logic [7:0]  sr, sg, sb, sa;
	logic [24:0] as_s63;
	logic [31:0] ak_s64, dk_s64;
	logic        faint_s64, faint_s65;
	logic [31:0] ok_s65;
	logic [2:0][39:0] pa_s65, pd_s65;
	logic [7:0]  ea_s65;
	logic [1:0]  sel_n;
	logic [7:0]  alpha_n;

	assign sr = brush_color_q[31:24];
	assign sg = brush_color_q[23:16];
	assign sb = brush_color_q[15:8];
	assign sa = brush_color_q[7:0];

	always_comb begin
		if (!car_s[65].touched || (!erase_mode_q && faint_s65)) begin
			sel_n = bdsb_pkg::SEL_DST;
		end else if (erase_mode_q) begin
			sel_n = bdsb_pkg::SEL_ERASE;
		end else if (ok_s65 < 32'(bdsb_pkg::VANISH_LIM)) begin
			sel_n = bdsb_pkg::SEL_ZERO;
		end else begin
			sel_n = bdsb_pkg::SEL_BLEND;
		end
		alpha_n = erase_mode_q ? ea_s65 : bdsb_pkg::div255(ok_s65[31:16]);
	end

	// colour divides, one quotient bit per stage (index 0 is stage 66)
	logic [2:0][39:0] cd_rem_s [0:CD_N];
	logic [2:0][7:0]  cd_q_s   [0:CD_N];
	logic [31:0]      cd_ok_s  [0:CD_N];
	logic [1:0]       cd_sel_s [0:CD_N];
	logic [7:0]       cd_a_s   [0:CD_N];
	logic [2:0][39:0] cd_rem_n [1:CD_N];
	logic [2:0][7:0]  cd_q_n   [1:CD_N];

	always_comb begin
		logic [39:0] sub;
		for (int j = 1; j <= CD_N; j++) begin
			sub = 40'(cd_ok_s[j-1]) << (CD_N - j);
			for (int c = 0; c < 3; c++) begin
				cd_rem_n[j][c] = cd_rem_s[j-1][c];
				cd_q_n[j][c]   = cd_q_s[j-1][c];
				if (cd_rem_s[j-1][c] >= sub) begin
					cd_rem_n[j][c]           = cd_rem_s[j-1][c] - sub;
					cd_q_n[j][c][CD_N - j]   = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			as_s63 <= 25'(fo_s62) * 25'(sa);
			ak_s64 <= 32'(as_s63) * 32'd255;
			dk_s64 <= 32'(car_s[63].a) * 32'(25'(bdsb_pkg::SRC_ONE) - as_s63);
			faint_s64 <= as_s63 <= 25'(bdsb_pkg::ALPHA_EPS);
			faint_s65 <= faint_s64;
			ok_s65    <= ak_s64 + dk_s64;
			pa_s65[0] <= 40'(sr) * 40'(ak_s64);
			pa_s65[1] <= 40'(sg) * 40'(ak_s64);
			pa_s65[2] <= 40'(sb) * 40'(ak_s64);
			pd_s65[0] <= 40'(car_s[64].r) * 40'(dk_s64);
			pd_s65[1] <= 40'(car_s[64].g) * 40'(dk_s64);
			pd_s65[2] <= 40'(car_s[64].b) * 40'(dk_s64);
			ea_s65    <= bdsb_pkg::div255(dk_s64[31:16]);
			for (int c = 0; c < 3; c++) cd_rem_s[0][c] <= pa_s65[c] + pd_s65[c];
			cd_q_s[0]   <= '0;
			cd_ok_s[0]  <= ok_s65;
			cd_sel_s[0] <= sel_n;
			cd_a_s[0]   <= alpha_n;
			for (int j = 1; j <= CD_N; j++) begin
				cd_rem_s[j] <= cd_rem_n[j];
				cd_q_s[j]   <= cd_q_n[j];
				cd_ok_s[j]  <= cd_ok_s[j-1];
				cd_sel_s[j] <= cd_sel_s[j-1];
				cd_a_s[j]   <= cd_a_s[j-1];
			end
		end
	end

	// output register
	logic [7:0] or_s75, og_s75, ob_s75, oa_s75;
	logic       touched_s75;

	always_ff @(posedge clk) begin
		if (adv) begin
			touched_s75 <= car_s[NST-1].touched;
			case (cd_sel_s[CD_N])
				bdsb_pkg::SEL_ERASE: begin
					or_s75 <= car_s[NST-1].r;
					og_s75 <= car_s[NST-1].g;
					ob_s75 <= car_s[NST-1].b;
					oa_s75 <= cd_a_s[CD_N];
				end
				bdsb_pkg::SEL_ZERO: begin
					or_s75 <= '0;
					og_s75 <= '0;
					ob_s75 <= '0;
					oa_s75 <= '0;
				end
				bdsb_pkg::SEL_BLEND: begin
					or_s75 <= cd_q_s[CD_N][0];
					og_s75 <= cd_q_s[CD_N][1];
					ob_s75 <= cd_q_s[CD_N][2];
					oa_s75 <= cd_a_s[CD_N];
				end
				default: begin
					or_s75 <= car_s[NST-1].r;
					og_s75 <= car_s[NST-1].g;
					ob_s75 <= car_s[NST-1].b;
					oa_s75 <= car_s[NST-1].a;
				end
			endcase
		end
	end

	assign pix_out.valid         = vld_s[NST];
	assign pix_out.out_red       = or_s75;
	assign pix_out.out_green     = og_s75;
	assign pix_out.out_blue      = ob_s75;
	assign pix_out.out_alpha     = oa_s75;
	assign pix_out.pixel_touched = touched_s75;

endmodule
